/* rtl/cfd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cfd_pkg: shared definitions of the complex FIR decimator
// Sizes, command codes and the control group between the sequencer and the
// multiply-accumulate unit.
// ----------------------------------------------------------------------------
package cfd_pkg;

    localparam int MAX_FACTOR     = 127;
    localparam int HIST_DEPTH     = 1024;
    localparam int DELAY_PER_SIDE = 4;

    localparam int FACTOR_W  = 7;
    localparam int CMD_W     = 1;
    localparam int TAP_IDX_W = 10;
    localparam int TAP_W     = 18;
    localparam int SMP_W     = 16;
    localparam int WORD_W    = 2 * SMP_W;
    localparam int FRAC_BITS = 17;

    localparam int HIST_AW   = $clog2(HIST_DEPTH);
    localparam int FILL_W    = $clog2(HIST_DEPTH + 1);
    localparam int DEPTH_MAX = (HIST_DEPTH - 1) / (2 * DELAY_PER_SIDE);
    localparam int FACT_LIM0 = (MAX_FACTOR < DEPTH_MAX) ? MAX_FACTOR : DEPTH_MAX;
    localparam int FACT_LIM  = (FACT_LIM0 < 1) ? 1 : FACT_LIM0;
    localparam int LEN_MAX   = 2 * DELAY_PER_SIDE * FACT_LIM + 1;
    localparam int LEN_W     = $clog2(LEN_MAX + 1);

    localparam int PROD_W     = TAP_W + SMP_W;
    localparam int ACC_W      = PROD_W + $clog2(LEN_MAX + 1);
    localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);
    localparam int SMP_MAX    = (1 << (SMP_W - 1)) - 1;
    localparam int SMP_MIN    = -(1 << (SMP_W - 1));

    localparam logic [CMD_W-1:0] CMD_PUSH = 1'b0;
    localparam logic [CMD_W-1:0] CMD_TAP  = 1'b1;

    typedef struct packed {
        logic vld;
        logic first;
        logic live;
    } t_mac_ctl;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_MAC   = 4'b0010,
        S_DRAIN = 4'b0100,
        S_OUT   = 4'b1000
    } t_state;

    function automatic logic [FACTOR_W-1:0] eff_factor(input logic [FACTOR_W-1:0] f);
        logic [FACTOR_W-1:0] m;
        m = f;
        if (m == '0) begin
            m = FACTOR_W'(1);
        end else if (m > FACTOR_W'(FACT_LIM)) begin
            m = FACTOR_W'(FACT_LIM);
        end
        return m;
    endfunction

endpackage
`default_nettype wire

/* rtl/cfd_store.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cfd_store: tap memory and sample history memory
// One write port and one registered read port per memory.
// ----------------------------------------------------------------------------
module cfd_store (
    input  wire logic                          i_clk,
    input  wire logic                          i_tap_we,
    input  wire logic [cfd_pkg::HIST_AW-1:0]   i_tap_waddr,
    input  wire logic [cfd_pkg::TAP_W-1:0]     i_tap_wdata,
    input  wire logic [cfd_pkg::HIST_AW-1:0]   i_tap_raddr,
    output logic      [cfd_pkg::TAP_W-1:0]     o_tap_q,
    input  wire logic                          i_hist_we,
    input  wire logic [cfd_pkg::HIST_AW-1:0]   i_hist_waddr,
    input  wire logic [cfd_pkg::WORD_W-1:0]    i_hist_wdata,
    input  wire logic [cfd_pkg::HIST_AW-1:0]   i_hist_raddr,
    output logic      [cfd_pkg::WORD_W-1:0]    o_hist_q
);
    import cfd_pkg::*;

    logic [TAP_W-1:0]  r_tap_mem  [HIST_DEPTH];
    logic [WORD_W-1:0] r_hist_mem [HIST_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_tap_we) begin
            r_tap_mem[i_tap_waddr] <= i_tap_wdata;
        end
        o_tap_q <= r_tap_mem[i_tap_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_hist_we) begin
            r_hist_mem[i_hist_waddr] <= i_hist_wdata;
        end
        o_hist_q <= r_hist_mem[i_hist_raddr];
    end

endmodule
`default_nettype wire

/* rtl/cfd_mac.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cfd_mac: shared complex-by-real multiply-accumulate unit
// Two-stage pipeline of product and sum, with rounding and saturation of the
// accumulated value.
// ----------------------------------------------------------------------------
module cfd_mac (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire cfd_pkg::t_mac_ctl             i_ctl,
    input  wire logic [cfd_pkg::TAP_W-1:0]     i_tap,
    input  wire logic [cfd_pkg::WORD_W-1:0]    i_word,
    output logic      [cfd_pkg::SMP_W-1:0]     o_res_re,
    output logic      [cfd_pkg::SMP_W-1:0]     o_res_im
);
    import cfd_pkg::*;

    logic signed [SMP_W-1:0]  w_re;
    logic signed [SMP_W-1:0]  w_im;
    logic signed [PROD_W-1:0] w_prod_re;
    logic signed [PROD_W-1:0] w_prod_im;
    logic signed [PROD_W-1:0] r_prod_re;
    logic signed [PROD_W-1:0] r_prod_im;
    t_mac_ctl                 r_p_ctl;
    logic signed [ACC_W-1:0]  r_acc_re;
    logic signed [ACC_W-1:0]  r_acc_im;
    logic signed [ACC_W-1:0]  w_base_re;
    logic signed [ACC_W-1:0]  w_base_im;

    // Entries older than anything written since reset read as zero.
    assign w_re = i_ctl.live ? $signed(i_word[WORD_W-1:SMP_W]) : '0;
    assign w_im = i_ctl.live ? $signed(i_word[SMP_W-1:0])      : '0;

    assign w_prod_re = $signed(i_tap) * w_re;
    assign w_prod_im = $signed(i_tap) * w_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_ctl <= '0;
        end else begin
            r_p_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod_re <= w_prod_re;
        r_prod_im <= w_prod_im;
    end

    assign w_base_re = r_p_ctl.first ? '0 : r_acc_re;
    assign w_base_im = r_p_ctl.first ? '0 : r_acc_im;

    always_ff @(posedge i_clk) begin
        if (r_p_ctl.vld) begin
            r_acc_re <= w_base_re + ACC_W'(r_prod_re);
            r_acc_im <= w_base_im + ACC_W'(r_prod_im);
        end
    end

    function automatic logic [SMP_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W:0] sum;
        logic signed [ACC_W:0] q;
        logic [SMP_W-1:0]      res;
        sum = (ACC_W+1)'(acc) + (ACC_W+1)'(ROUND_HALF);
        q   = sum >>> FRAC_BITS;
        if (q > (ACC_W+1)'(SMP_MAX)) begin
            res = SMP_W'(SMP_MAX);
        end else if (q < (ACC_W+1)'(SMP_MIN)) begin
            res = SMP_W'(SMP_MIN);
        end else begin
            res = SMP_W'(q);
        end
        return res;
    endfunction

    assign o_res_re = round_sat(r_acc_re);
    assign o_res_im = round_sat(r_acc_im);

endmodule
`default_nettype wire

/* rtl/complex_fir_decimator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// complex_fir_decimator: decimating FIR filter, complex samples, real taps
// Requests arrive on a valid/ready input channel. A tap request stores one
// Q1.17 tap word by index; a sample request pushes one complex sample. With
// factor M the filter has 8*M+1 taps, and every M-th sample gives one
// result on the valid/ready output channel. Factor 1 passes samples through.
// A tap request or a sample request that gives no result leaves the input
// ready. The M-th sample starts a result: one shared complex-by-real
// multiply-accumulate unit handles one tap per cycle, followed by memory read,
// product and sum stages and the output load. A passthrough sample goes from
// a holding register to the output register. The input is not ready while
// a result is being computed or waits to be loaded into the output register;
// the register holds a result while the receiver stalls, and requests that
// give no result are still taken then. After reset the factor is 1 and the
// sample history reads as zero through a fill count, so no clearing pass is
// needed. Taps must be loaded before use. The factor register must be
// written only while the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module complex_fir_decimator (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [cfd_pkg::FACTOR_W-1:0]      i_cfg_wr_data,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [cfd_pkg::CMD_W-1:0]         i_command,
    input  wire logic [cfd_pkg::TAP_IDX_W-1:0]     i_tap_index,
    input  wire logic signed [cfd_pkg::TAP_W-1:0]  i_tap_value,
    input  wire logic signed [cfd_pkg::SMP_W-1:0]  i_sample_re,
    input  wire logic signed [cfd_pkg::SMP_W-1:0]  i_sample_im,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic signed [cfd_pkg::SMP_W-1:0]       o_out_re,
    output logic signed [cfd_pkg::SMP_W-1:0]       o_out_im
);
    import cfd_pkg::*;

    localparam logic [1:0] DRAIN_LAST = 2'd1;

    t_state                r_state;
    t_state                n_state;
    logic [FACTOR_W-1:0]   r_factor;
    logic [FACTOR_W-1:0]   w_m;
    logic [LEN_W-1:0]      w_len_m1;
    logic [FACTOR_W-1:0]   r_phase;
    logic [HIST_AW-1:0]    r_newest;
    logic [HIST_AW-1:0]    w_next_pos;
    logic [FILL_W-1:0]     r_fill;
    logic [LEN_W-1:0]      r_k;
    logic [LEN_W-1:0]      n_k;
    logic [LEN_W-1:0]      r_age;
    logic [LEN_W-1:0]      n_age;
    logic [1:0]            r_drain;
    logic [1:0]            n_drain;
    logic                  r_pass;
    logic [SMP_W-1:0]      r_pt_re;
    logic [SMP_W-1:0]      r_pt_im;
    logic                  w_accept;
    logic                  w_push;
    logic                  w_tap_we;
    logic                  w_pass;
    logic                  w_hist_we;
    logic                  w_fire;
    logic                  w_out_free;
    logic                  w_live;
    logic [HIST_AW:0]      w_base;
    logic [HIST_AW:0]      w_age_x;
    logic [HIST_AW-1:0]    w_hist_raddr;
    t_mac_ctl              w_ctl;
    t_mac_ctl              r_rd_ctl;
    logic [TAP_W-1:0]      w_tap_q;
    logic [WORD_W-1:0]     w_hist_q;
    logic [SMP_W-1:0]      w_res_re;
    logic [SMP_W-1:0]      w_res_im;

    assign w_m      = eff_factor(r_factor);
    assign w_len_m1 = LEN_W'(w_m) * LEN_W'(2 * DELAY_PER_SIDE);

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_push     = w_accept && (i_command == CMD_PUSH);
    assign w_tap_we   = w_accept && (i_command == CMD_TAP)
                        && ((TAP_IDX_W+1)'(i_tap_index) < (TAP_IDX_W+1)'(HIST_DEPTH));
    assign w_pass     = w_push && (w_m == FACTOR_W'(1));
    assign w_hist_we  = w_push && !w_pass;
    assign w_fire     = w_hist_we
                        && !(((FACTOR_W+1)'(r_phase) + (FACTOR_W+1)'(1)) < (FACTOR_W+1)'(w_m));
    assign w_out_free = !o_out_valid || i_out_ready;

    assign w_next_pos = (r_newest == HIST_AW'(HIST_DEPTH - 1)) ? '0 : r_newest + 1'b1;

    assign w_base       = (HIST_AW+1)'(r_newest);
    assign w_age_x      = (HIST_AW+1)'(r_age);
    assign w_hist_raddr = (w_base >= w_age_x) ? HIST_AW'(w_base - w_age_x)
                          : HIST_AW'(w_base + (HIST_AW+1)'(HIST_DEPTH) - w_age_x);
    assign w_live       = (FILL_W+LEN_W)'(r_age) < (FILL_W+LEN_W)'(r_fill);

    assign w_ctl.vld   = (r_state == S_MAC);
    assign w_ctl.first = (r_k == '0);
    assign w_ctl.live  = w_live;

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_age   = r_age;
        n_drain = r_drain;
        unique case (r_state)
            S_IDLE: begin
                if (w_pass) begin
                    n_state = S_OUT;
                end else if (w_fire) begin
                    n_state = S_MAC;
                    n_k     = '0;
                    n_age   = w_len_m1;
                end
            end
            S_MAC: begin
                n_k   = r_k + 1'b1;
                n_age = r_age - 1'b1;
                if (r_age == '0) begin
                    n_state = S_DRAIN;
                    n_drain = '0;
                end
            end
            S_DRAIN: begin
                n_drain = r_drain + 1'b1;
                if (r_drain == DRAIN_LAST) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_factor    <= FACTOR_W'(1);
            r_phase     <= '0;
            r_newest    <= '0;
            r_fill      <= '0;
            r_k         <= '0;
            r_age       <= '0;
            r_drain     <= '0;
            r_pass      <= 1'b0;
            r_rd_ctl    <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_k      <= n_k;
            r_age    <= n_age;
            r_drain  <= n_drain;
            r_rd_ctl <= w_ctl;
            if (i_cfg_wr_en) begin
                r_factor <= i_cfg_wr_data;
            end
            if (w_hist_we) begin
                r_newest <= w_next_pos;
                if (r_fill != FILL_W'(HIST_DEPTH)) begin
                    r_fill <= r_fill + 1'b1;
                end
                r_phase <= w_fire ? '0 : r_phase + 1'b1;
            end
            if (w_pass) begin
                r_pass <= 1'b1;
            end else if (w_fire) begin
                r_pass <= 1'b0;
            end
            if (r_state == S_OUT && w_out_free) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pass) begin
            r_pt_re <= i_sample_re;
            r_pt_im <= i_sample_im;
        end
        if (r_state == S_OUT && w_out_free) begin
            o_out_re <= r_pass ? r_pt_re : w_res_re;
            o_out_im <= r_pass ? r_pt_im : w_res_im;
        end
    end

    cfd_store u_store (
        .i_clk        (i_clk),
        .i_tap_we     (w_tap_we),
        .i_tap_waddr  (HIST_AW'(i_tap_index)),
        .i_tap_wdata  (i_tap_value),
        .i_tap_raddr  (HIST_AW'(r_k)),
        .o_tap_q      (w_tap_q),
        .i_hist_we    (w_hist_we),
        .i_hist_waddr (w_next_pos),
        .i_hist_wdata ({i_sample_re, i_sample_im}),
        .i_hist_raddr (w_hist_raddr),
        .o_hist_q     (w_hist_q)
    );

    cfd_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (r_rd_ctl),
        .i_tap    (w_tap_q),
        .i_word   (w_hist_q),
        .o_res_re (w_res_re),
        .o_res_im (w_res_im)
    );

`ifndef ASSERT_OFF
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && w_out_free) |=> o_out_valid)
        else $error("result was not loaded into the output register");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(HIST_DEPTH))
        else $error("history fill count passed the depth");

    a_tap_age: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC) |-> ((LEN_W+1)'(r_k) + (LEN_W+1)'(r_age) == (LEN_W+1)'(w_len_m1)))
        else $error("tap index and sample age are out of step");

    a_busy_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> !o_in_ready)
        else $error("input taken while a result is being computed");
`endif

endmodule
`default_nettype wire
